// ===== rtl/masked_mismatch_count_with_limit_core_macros.svh =====
// ============================================================================
// Masked mismatch counter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef MASKED_MISMATCH_COUNT_WITH_LIMIT_CORE_MACROS_SVH
`define MASKED_MISMATCH_COUNT_WITH_LIMIT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMCL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("masked mismatch counter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MMCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("masked mismatch counter: next-cycle check failed");

`endif

// ===== rtl/mmcl_pkg.sv =====
// ============================================================================
// Masked mismatch counter package
// Widths, operation codes, the control state type and the nibble compare.
// ============================================================================
package mmcl_pkg;

  localparam int WORD_W          = 32;
  localparam int NIBBLES         = 8;
  localparam int ADDR_FIELD_W    = 10;
  localparam int COUNT_W         = 14;
  localparam int FUNC_W          = 2;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam logic [COUNT_W-1:0] MAX_SUM = COUNT_W'(8192);

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Counts nibbles whose low three bits differ, skipping any nibble pair in
  // which either side has its low three bits all zero.
  function automatic logic [3:0] pair_mismatches(input logic [WORD_W-1:0] wa,
                                                 input logic [WORD_W-1:0] wb);
    logic [NIBBLES-1:0] hit;
    logic [2:0]         x;
    logic [2:0]         y;
    for (int k = 0; k < NIBBLES; k++) begin
      x      = wa[4*k +: 3];
      y      = wb[4*k +: 3];
      hit[k] = (x != 3'd0) && (y != 3'd0) && (x != y);
    end
    return 4'($countones(hit));
  endfunction

endpackage

// ===== rtl/mmcl_in_if.sv =====
// ============================================================================
// Masked mismatch counter input channel
// Valid/ready channel that carries one load or compare transaction.
// ============================================================================
interface mmcl_in_if import mmcl_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [ADDR_FIELD_W-1:0] load_addr;
  logic [WORD_W-1:0]       load_word;
  logic [ADDR_FIELD_W-1:0] start_a;
  logic [ADDR_FIELD_W-1:0] start_b;
  logic [ADDR_FIELD_W-1:0] word_count;
  logic                    direction;

  modport source (
    output valid, func, load_addr, load_word, start_a, start_b, word_count, direction,
    input  ready
  );

  modport sink (
    input  valid, func, load_addr, load_word, start_a, start_b, word_count, direction,
    output ready
  );

endinterface

// ===== rtl/mmcl_out_if.sv =====
// ============================================================================
// Masked mismatch counter result channel
// Valid/ready channel that carries one compare result transaction.
// ============================================================================
interface mmcl_out_if import mmcl_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] mismatch_count;
  logic               within_limit;

  modport source (
    output valid, mismatch_count, within_limit,
    input  ready
  );

  modport sink (
    input  valid, mismatch_count, within_limit,
    output ready
  );

endinterface

// ===== rtl/mmcl_cfg_if.sv =====
// ============================================================================
// Masked mismatch counter configuration channel
// Valid/ready write channel for the mismatch limit register.
// ============================================================================
interface mmcl_cfg_if import mmcl_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] max_mismatches;

  modport source (
    output valid, max_mismatches,
    input  ready
  );

  modport sink (
    input  valid, max_mismatches,
    output ready
  );

endinterface

// ===== rtl/mmcl_store.sv =====
// ============================================================================
// Masked mismatch counter word store
// Single-port-write, single-port-read synchronous memory with registered read data.
// ============================================================================
module mmcl_store import mmcl_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(STORE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [STORE_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/masked_mismatch_count_with_limit_core.sv =====
// ============================================================================
// Masked mismatch counter with limit
// Two word stores of packed 4-bit nucleotide codes and a limited compare walk.
// ============================================================================
// The block handles one transaction at a time. A load (func 0 or 1) writes
// load_word into store A or B after R address reduction steps, where R is
// zero when STORE_DEPTH is at least 1024 and otherwise the number of
// quotient bits of a 10-bit address divided by STORE_DEPTH. A compare
// (func 2) runs the same R reduction steps and then walks its word pairs:
// both stores are read once per cycle through their single read port, so
// the walk moves one pair per cycle. The walk ends early on the pair that
// pushes the sum above max_mismatches. A compare also holds the input side
// for as long as its finished result waits for the output register to free
// up. Func 3 is accepted and dropped. A finished result sits in an output
// register, so the next transaction is accepted while the previous result
// still waits for the sink. The limit register may only be written while no
// compare is in flight or waiting to be delivered.
// ============================================================================
module masked_mismatch_count_with_limit_core import mmcl_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmcl_in_if.sink   in_i,
  mmcl_out_if.source out_o,
  mmcl_cfg_if.sink  cfg_i
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PAIR_W = ADDR_FIELD_W + 1;
  localparam int RED_W  = ADDR_FIELD_W + 1;
  // Number of conditional subtract steps to bring a 10-bit address below
  // the store depth.
  localparam int REDUCE_STEPS = $clog2(((2**ADDR_FIELD_W) - 1) / STORE_DEPTH + 1);
  localparam int STEP_W       = (REDUCE_STEPS > 0) ? $clog2(REDUCE_STEPS + 1) : 1;
  localparam logic [RED_W-1:0] DEPTH_R =
    (STORE_DEPTH > (2**ADDR_FIELD_W)) ? '0 : RED_W'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // One restoring step of the address reduction.
  function automatic logic [ADDR_FIELD_W-1:0] red_step(input logic [ADDR_FIELD_W-1:0] x,
                                                       input logic [RED_W-1:0]        c);
    if ({1'b0, x} >= c) begin
      return x - c[ADDR_FIELD_W-1:0];
    end
    return x;
  endfunction

  state_e state_q, state_d;

  logic [FUNC_W-1:0]       func_q, func_d;
  logic                    dir_q, dir_d;
  logic [ADDR_FIELD_W-1:0] la_q, la_d;
  logic [ADDR_FIELD_W-1:0] sa_q, sa_d;
  logic [ADDR_FIELD_W-1:0] sb_q, sb_d;
  logic [WORD_W-1:0]       word_q, word_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [PAIR_W-1:0]       pairs_q, pairs_d;
  logic [PAIR_W-1:0]       issue_left_q, issue_left_d;
  logic [PAIR_W-1:0]       acc_left_q, acc_left_d;
  logic [ADDR_W-1:0]       addr_a_q, addr_a_d;
  logic [ADDR_W-1:0]       addr_b_q, addr_b_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [COUNT_W-1:0]      sum_q, sum_d;
  logic                    ok_q, ok_d;
  logic [COUNT_W-1:0]      limit_q, limit_d;
  logic                    out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;
  logic                    out_ok_q, out_ok_d;

  logic                    in_fire;
  logic                    in_known;
  logic                    out_free;
  logic                    we_a;
  logic                    we_b;
  logic                    re;
  logic [WORD_W-1:0]       rdata_a;
  logic [WORD_W-1:0]       rdata_b;
  logic [3:0]              pair_mm;
  logic [COUNT_W-1:0]      sum_new;
  logic                    over;
  logic                    last_pair;
  logic [ADDR_FIELD_W-1:0] span;
  logic [PAIR_W-1:0]       pairs_in;
  logic [RED_W-1:0]        sub_c;

  // The input side is open whenever the sequencer is idle; the result
  // register decouples it from the sink.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_known    = (in_i.func == FUNC_LOAD_A) || (in_i.func == FUNC_LOAD_B) ||
                       (in_i.func == FUNC_COMPARE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid          = out_valid_q;
  assign out_o.mismatch_count = out_count_q;
  assign out_o.within_limit   = out_ok_q;

  // Walk length. Descending walks cover start_a down to max(start_a - count, 0),
  // ascending walks cover count pairs with a minimum of one.
  always_comb begin
    span = (in_i.start_a >= in_i.word_count) ? in_i.word_count : in_i.start_a;
    if (in_i.direction) begin
      pairs_in = (in_i.word_count == '0) ? PAIR_W'(1) : PAIR_W'(in_i.word_count);
    end else begin
      pairs_in = PAIR_W'(span) + PAIR_W'(1);
    end
  end

  // Accumulator stage, fed by the registered read data of both stores.
  assign pair_mm   = pair_mismatches(rdata_a, rdata_b);
  assign sum_new   = sum_q + COUNT_W'(pair_mm);
  assign over      = sum_new > limit_q;
  assign last_pair = (acc_left_q == PAIR_W'(1));
  assign sub_c     = DEPTH_R << (step_q - STEP_W'(1));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_known) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (step_q == '0) begin
          state_d = (func_q == FUNC_COMPARE) ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        if (rd_valid_q && (over || last_pair)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    func_d       = func_q;
    dir_d        = dir_q;
    la_d         = la_q;
    sa_d         = sa_q;
    sb_d         = sb_q;
    word_d       = word_q;
    step_d       = step_q;
    pairs_d      = pairs_q;
    issue_left_d = issue_left_q;
    acc_left_d   = acc_left_q;
    addr_a_d     = addr_a_q;
    addr_b_d     = addr_b_q;
    rd_valid_d   = 1'b0;
    sum_d        = sum_q;
    ok_d         = ok_q;
    limit_d      = limit_q;
    out_count_d  = out_count_q;
    out_ok_d     = out_ok_q;
    we_a         = 1'b0;
    we_b         = 1'b0;
    re           = 1'b0;

    if (cfg_i.valid && cfg_i.ready) begin
      limit_d = cfg_i.max_mismatches;
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d  = in_i.func;
          dir_d   = in_i.direction;
          la_d    = in_i.load_addr;
          sa_d    = in_i.start_a;
          sb_d    = in_i.start_b;
          word_d  = in_i.load_word;
          step_d  = STEP_W'(REDUCE_STEPS);
          pairs_d = pairs_in;
        end
      end
      ST_REDUCE: begin
        if (step_q != '0) begin
          la_d   = red_step(la_q, sub_c);
          sa_d   = red_step(sa_q, sub_c);
          sb_d   = red_step(sb_q, sub_c);
          step_d = step_q - STEP_W'(1);
        end else begin
          we_a         = (func_q == FUNC_LOAD_A);
          we_b         = (func_q == FUNC_LOAD_B);
          addr_a_d     = ADDR_W'(sa_q);
          addr_b_d     = ADDR_W'(sb_q);
          issue_left_d = pairs_q;
          acc_left_d   = pairs_q;
          sum_d        = '0;
          ok_d         = 1'b1;
        end
      end
      ST_WALK: begin
        // Read issue: one address pair per cycle until the span is covered.
        if (issue_left_q != '0) begin
          re           = 1'b1;
          rd_valid_d   = 1'b1;
          issue_left_d = issue_left_q - PAIR_W'(1);
          if (dir_q) begin
            addr_a_d = (addr_a_q == LAST_ADDR) ? '0 : addr_a_q + ADDR_W'(1);
            addr_b_d = (addr_b_q == LAST_ADDR) ? '0 : addr_b_q + ADDR_W'(1);
          end else begin
            addr_a_d = (addr_a_q == '0) ? LAST_ADDR : addr_a_q - ADDR_W'(1);
            addr_b_d = (addr_b_q == '0) ? LAST_ADDR : addr_b_q - ADDR_W'(1);
          end
        end
        // Accumulate: reads still in flight after a stop are simply dropped.
        if (rd_valid_q) begin
          sum_d      = sum_new;
          acc_left_d = acc_left_q - PAIR_W'(1);
          if (over) begin
            ok_d = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = sum_q;
          out_ok_d    = ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      func_q       <= FUNC_LOAD_A;
      dir_q        <= 1'b0;
      step_q       <= '0;
      pairs_q      <= '0;
      issue_left_q <= '0;
      acc_left_q   <= '0;
      rd_valid_q   <= 1'b0;
      limit_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      dir_q        <= dir_d;
      step_q       <= step_d;
      pairs_q      <= pairs_d;
      issue_left_q <= issue_left_d;
      acc_left_q   <= acc_left_d;
      rd_valid_q   <= rd_valid_d;
      limit_q      <= limit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q        <= la_d;
    sa_q        <= sa_d;
    sb_q        <= sb_d;
    word_q      <= word_d;
    addr_a_q    <= addr_a_d;
    addr_b_q    <= addr_b_d;
    sum_q       <= sum_d;
    ok_q        <= ok_d;
    out_count_q <= out_count_d;
    out_ok_q    <= out_ok_d;
  end

  mmcl_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ADDR_W'(la_q)),
    .wdata_i (word_q),
    .re_i    (re),
    .raddr_i (addr_a_q),
    .rdata_o (rdata_a)
  );

  mmcl_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (ADDR_W'(la_q)),
    .wdata_i (word_q),
    .re_i    (re),
    .raddr_i (addr_b_q),
    .rdata_o (rdata_b)
  );

endmodule

// ===== rtl/mmcl_checker.sv =====
// ============================================================================
// Masked mismatch counter port checker
// Concurrent checks on the result channel, bound to the top level.
// ============================================================================
`include "masked_mismatch_count_with_limit_core_macros.svh"

module mmcl_checker import mmcl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] out_count_i,
  input logic               out_ok_i
);

  // A stalled result stays offered and unchanged.
  `MMCL_ASSERT_NEXT(a_out_held, out_valid_i && !out_ready_i, out_valid_i)
  `MMCL_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_count_i) && $stable(out_ok_i))

  // A walk covers at most 1024 pairs of eight nibbles.
  `MMCL_ASSERT_SAME(a_count_range, out_valid_i, out_count_i <= MAX_SUM)

  // A failed compare has crossed a limit of at least zero.
  `MMCL_ASSERT_SAME(a_fail_nonzero, out_valid_i && !out_ok_i, out_count_i != '0)

endmodule

bind masked_mismatch_count_with_limit_core mmcl_checker u_mmcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.mismatch_count),
  .out_ok_i    (out_o.within_limit)
);
